// ===== design/tgsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsa_pkg
// Shared constants and types for the temporal graph suffix array / Psi core.
// ----------------------------------------------------------------------------
package tgsa_pkg;

    localparam int MAX_CONTACTS_DEF = 16;
    localparam int ID_BITS_DEF      = 16;

    localparam int IN_FIELD_W = 16;
    localparam int RANK_W     = 6;
    localparam int SUFFIX_W   = 7;
    localparam int PSI_W      = 7;
    localparam int OUT_DATA_W = 24;
    localparam int IN_DATA_W  = 4 * IN_FIELD_W;

    // result of one symbol comparison in the shared compare unit
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== design/tgsa_sym_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsa_sym_mem
// Contact store: one row of four raw symbols per contact, one write port and
// two registered read ports.
// ----------------------------------------------------------------------------
module tgsa_sym_mem #(
    parameter int ROWS   = 16,
    parameter int ROW_AW = 4,
    parameter int SYM_W  = 16
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ROW_AW-1:0]    wr_addr,
    input  logic [4*SYM_W-1:0]   wr_data,
    input  logic [ROW_AW-1:0]    rd_addr_a,
    input  logic [ROW_AW-1:0]    rd_addr_b,
    output logic [4*SYM_W-1:0]   rd_data_a,
    output logic [4*SYM_W-1:0]   rd_data_b
);

    logic [4*SYM_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/tgsa_rank_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsa_rank_mem
// Single-port-write, single-port-read table for suffix order and its inverse.
// ----------------------------------------------------------------------------
module tgsa_rank_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/tgsa_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsa_cmp
// Shared compare unit: picks a column from each row, adds the column offset
// and compares the two offset symbols.
// ----------------------------------------------------------------------------
module tgsa_cmp
    import tgsa_pkg::*;
#(
    parameter int SYM_W = 16
) (
    input  logic [4*SYM_W-1:0] row_a,
    input  logic [1:0]         col_a,
    input  logic [4*SYM_W-1:0] row_b,
    input  logic [1:0]         col_b,
    input  logic [SYM_W+1:0]   off1,
    input  logic [SYM_W+1:0]   off2,
    input  logic [SYM_W+1:0]   off3,
    output cmp_res_t           res
);

    localparam int OFF_W = SYM_W + 2;

    logic [OFF_W-1:0] sym_a;
    logic [OFF_W-1:0] sym_b;

    function automatic logic [OFF_W-1:0] offset_sym(
        input logic [4*SYM_W-1:0] row,
        input logic [1:0]         col,
        input logic [OFF_W-1:0]   o1,
        input logic [OFF_W-1:0]   o2,
        input logic [OFF_W-1:0]   o3
    );
        logic [OFF_W-1:0] raw;
        logic [OFF_W-1:0] off;
        raw = {2'b00, row[col*SYM_W +: SYM_W]};
        case (col)
            2'd0:    off = '0;
            2'd1:    off = o1;
            2'd2:    off = o2;
            default: off = o3;
        endcase
        return raw + off;
    endfunction

    assign sym_a  = offset_sym(row_a, col_a, off1, off2, off3);
    assign sym_b  = offset_sym(row_b, col_b, off1, off2, off3);
    assign res.lt = sym_a < sym_b;
    assign res.eq = sym_a == sym_b;

endmodule

// ===== design/temporal_graph_suffix_array_psi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_graph_suffix_array_psi_core
// Flow: contacts load one per cycle while s_tready is high; after the last
//   contact the rank pass compares every suffix pair (L = 4n suffixes) one
//   symbol at a time in the single compare unit, then emits each table entry.
// Throughput: one contact set at a time; s_tready is low from the last
//   contact until the final result transaction.
// Reset: aresetn synchronous active low; clears the sequencer, the contact count and the running maxima.
// ----------------------------------------------------------------------------
module temporal_graph_suffix_array_psi_core
    import tgsa_pkg::*;
#(
    parameter int MAX_CONTACTS = MAX_CONTACTS_DEF,
    parameter int ID_BITS      = ID_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_from[15:0], vertex_to[31:16], time_start[47:32], time_end[63:48]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,   // last_contact
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rank_index[5:0], suffix_start[12:6], psi_value[19:13], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast    // last_result
);

    localparam int SYM_W  = (ID_BITS < IN_FIELD_W) ? ID_BITS : IN_FIELD_W;
    localparam int OFF_W  = SYM_W + 2;
    localparam int SEQ_D  = 4 * MAX_CONTACTS;
    localparam int ROW_AW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int SEQ_AW = $clog2(SEQ_D);
    localparam int CNT_W  = $clog2(MAX_CONTACTS + 1);
    localparam int LEN_W  = $clog2(SEQ_D + 1);

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_PREP = 9'b000000010,
        S_RD   = 9'b000000100,
        S_EV   = 9'b000001000,
        S_O1   = 9'b000010000,
        S_O2   = 9'b000100000,
        S_O3   = 9'b001000000,
        S_MOD  = 9'b010000000,
        S_SEND = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [SYM_W-1:0] mv_reg, mt_reg;
    logic [OFF_W-1:0] off1_reg, off2_reg, off3_reg;
    logic [LEN_W-1:0] len_reg, i_reg, j_reg, k_reg, rank_reg;
    logic [LEN_W-1:0] r_reg, s_reg, psi_reg;
    logic [LEN_W:0]   t_reg;

    // load path
    logic [SYM_W-1:0] in_u, in_v, in_ts, in_te;
    logic [SYM_W-1:0] mv_next, mt_next, mv_a, mt_a;
    logic             s_acc, store_en;
    logic [CNT_W-1:0] cnt_next;

    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign in_u     = s_tdata[0*IN_FIELD_W +: SYM_W];
    assign in_v     = s_tdata[1*IN_FIELD_W +: SYM_W];
    assign in_ts    = s_tdata[2*IN_FIELD_W +: SYM_W];
    assign in_te    = s_tdata[3*IN_FIELD_W +: SYM_W];
    assign store_en = s_acc && (cnt_reg < CNT_W'(MAX_CONTACTS));

    always_comb begin
        mv_a     = (in_u > mv_reg) ? in_u : mv_reg;
        mt_a     = (in_ts > mt_reg) ? in_ts : mt_reg;
        mv_next  = mv_reg;
        mt_next  = mt_reg;
        cnt_next = cnt_reg;
        if (store_en) begin
            mv_next  = (in_v > mv_a) ? in_v : mv_a;
            mt_next  = (in_te > mt_a) ? in_te : mt_a;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // rank pass
    logic [LEN_W:0]     ik, jk;
    logic [4*SYM_W-1:0] row_i, row_j;
    cmp_res_t           cmp;
    logic               decide, less, row_done;
    logic [LEN_W-1:0]   rank_inc;

    assign ik = {1'b0, i_reg} + {1'b0, k_reg};
    assign jk = {1'b0, j_reg} + {1'b0, k_reg};

    tgsa_sym_mem #(
        .ROWS   (MAX_CONTACTS),
        .ROW_AW (ROW_AW),
        .SYM_W  (SYM_W)
    ) u_sym_mem (
        .aclk      (aclk),
        .wr_en     (store_en),
        .wr_addr   (ROW_AW'(cnt_reg)),
        .wr_data   ({in_te, in_ts, in_v, in_u}),
        .rd_addr_a (ROW_AW'(jk >> 2)),
        .rd_addr_b (ROW_AW'(ik >> 2)),
        .rd_data_a (row_j),
        .rd_data_b (row_i)
    );

    // suffix j against suffix i at the current depth
    tgsa_cmp #(
        .SYM_W (SYM_W)
    ) u_cmp (
        .row_a (row_j),
        .col_a (jk[1:0]),
        .row_b (row_i),
        .col_b (ik[1:0]),
        .off1  (off1_reg),
        .off2  (off2_reg),
        .off3  (off3_reg),
        .res   (cmp)
    );

    always_comb begin
        decide = 1'b0;
        less   = 1'b0;
        if (state_reg == S_RD) begin
            if (i_reg == j_reg) begin
                decide = 1'b1;
            end else if ((ik >= {1'b0, len_reg}) || (jk >= {1'b0, len_reg})) begin
                decide = 1'b1;
                less   = (jk >= {1'b0, len_reg});
            end
        end else if (state_reg == S_EV) begin
            decide = !cmp.eq;
            less   = cmp.lt;
        end
    end

    assign rank_inc = rank_reg + LEN_W'(less);
    assign row_done = decide && (j_reg + 1'b1 == len_reg);

    // order tables
    logic [SEQ_AW-1:0] sa_rd, inv_rd;

    tgsa_rank_mem #(
        .DEPTH (SEQ_D),
        .AW    (SEQ_AW)
    ) u_sa_mem (
        .aclk    (aclk),
        .wr_en   (row_done),
        .wr_addr (rank_inc[SEQ_AW-1:0]),
        .wr_data (i_reg[SEQ_AW-1:0]),
        .rd_addr (r_reg[SEQ_AW-1:0]),
        .rd_data (sa_rd)
    );

    tgsa_rank_mem #(
        .DEPTH (SEQ_D),
        .AW    (SEQ_AW)
    ) u_inv_mem (
        .aclk    (aclk),
        .wr_en   (row_done),
        .wr_addr (i_reg[SEQ_AW-1:0]),
        .wr_data (rank_inc[SEQ_AW-1:0]),
        .rd_addr (sa_rd + 1'b1),
        .rd_data (inv_rd)
    );

    // emission
    logic [LEN_W-1:0] psi0, n_ext;
    logic [LEN_W-1:0] s_plus1;

    assign n_ext   = LEN_W'(cnt_reg);
    assign s_plus1 = s_reg + 1'b1;
    assign psi0    = (s_plus1 >= len_reg) ? LEN_W'(1) : (LEN_W'(inv_rd) + 1'b1);

    assign m_tvalid = (state_reg == S_SEND);
    assign m_tlast  = (r_reg + 1'b1 == len_reg);
    assign m_tdata  = {{(OUT_DATA_W - RANK_W - SUFFIX_W - PSI_W){1'b0}},
                       PSI_W'(psi_reg), SUFFIX_W'(s_plus1), RANK_W'(r_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            mv_reg    <= '0;
            mt_reg    <= '0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    cnt_reg <= cnt_next;
                    mv_reg  <= mv_next;
                    mt_reg  <= mt_next;
                    if (s_acc && s_tlast) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    off1_reg  <= OFF_W'(mv_reg);
                    off2_reg  <= OFF_W'(mv_reg) << 1;
                    off3_reg  <= (OFF_W'(mv_reg) << 1) + OFF_W'(mt_reg);
                    len_reg   <= LEN_W'(cnt_reg) << 2;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    k_reg     <= '0;
                    rank_reg  <= '0;
                    state_reg <= S_RD;
                end
                S_RD, S_EV: begin
                    if (decide) begin
                        k_reg <= '0;
                        if (row_done) begin
                            j_reg    <= '0;
                            rank_reg <= '0;
                            i_reg    <= i_reg + 1'b1;
                            if (i_reg + 1'b1 == len_reg) begin
                                r_reg     <= '0;
                                state_reg <= S_O1;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            rank_reg  <= rank_inc;
                            state_reg <= S_RD;
                        end
                    end else if (state_reg == S_RD) begin
                        state_reg <= S_EV;
                    end else begin
                        // symbols match: go one deeper
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_O1: begin
                    state_reg <= S_O2;
                end
                S_O2: begin
                    s_reg     <= LEN_W'(sa_rd);
                    state_reg <= S_O3;
                end
                S_O3: begin
                    if (r_reg >= len_reg - n_ext) begin
                        t_reg     <= {1'b0, psi0} + {1'b0, n_ext} - (LEN_W + 1)'(2);
                        state_reg <= S_MOD;
                    end else begin
                        psi_reg   <= psi0;
                        state_reg <= S_SEND;
                    end
                end
                S_MOD: begin
                    if (t_reg >= {1'b0, n_ext}) begin
                        t_reg <= t_reg - {1'b0, n_ext};
                    end else begin
                        psi_reg   <= LEN_W'(t_reg) + 1'b1;
                        state_reg <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (m_tready) begin
                        if (m_tlast) begin
                            cnt_reg   <= '0;
                            mv_reg    <= '0;
                            mt_reg    <= '0;
                            state_reg <= S_LOAD;
                        end else begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_O1;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/temporal_graph_suffix_array_psi_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_graph_suffix_array_psi_core_test
// Drives sets of temporal contacts into the suffix array / Psi core, predicts
// the emitted suffix table per set and checks every result transaction field
// by field, under several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module temporal_graph_suffix_array_psi_core_test
    import tgsa_pkg::*;
();

    localparam int NCT = MAX_CONTACTS_DEF;
    localparam int SEQ = 4 * NCT;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [SUFFIX_W-1:0] start;
        logic [PSI_W-1:0]    psi;
        logic                last;
    } table_entry_t;

    class psi_table_board;
        logic [17:0] sym [SEQ];
        int unsigned held;
        logic [17:0] max_vtx;
        logic [17:0] max_tim;
        table_entry_t pending [$];
        int errors;

        function new();
            held = 0;
            max_vtx = 0;
            max_tim = 0;
            errors = 0;
        endfunction

        function bit suffix_below(int a, int b, int len);
            while (a < len && b < len) begin
                if (sym[a] != sym[b]) return sym[a] < sym[b];
                a++;
                b++;
            end
            return a >= len && b < len;
        endfunction

        // note one accepted contact; build the table when it closes the set
        function void note_contact(logic [63:0] d, logic lst);
            int order [SEQ];
            int inv [SEQ];
            int len, s, j, p;
            logic [17:0] f;
            table_entry_t e;
            if (held < NCT) begin
                for (int k = 0; k < 4; k++) begin
                    f = {2'b00, d[16*k +: 16]};
                    sym[4*held + k] = f;
                    if (k < 2 && f > max_vtx) max_vtx = f;
                    if (k >= 2 && f > max_tim) max_tim = f;
                end
                held++;
            end
            if (!lst) return;
            len = 4 * held;
            for (int i = 0; i < held; i++) begin
                sym[4*i+1] += max_vtx;
                sym[4*i+2] += max_vtx << 1;
                sym[4*i+3] += (max_vtx << 1) + max_tim;
            end
            for (int i = 0; i < len; i++) begin
                j = i;
                while (j > 0 && suffix_below(i, order[j-1], len)) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int r = 0; r < len; r++) inv[order[r]] = r;
            for (int r = 0; r < len; r++) begin
                s = order[r];
                p = (s + 1 >= len) ? 1 : inv[s+1] + 1;
                if (r >= 3 * held) p = ((p + held - 2) % held) + 1;
                e.rank = RANK_W'(r);
                e.start = SUFFIX_W'(s + 1);
                e.psi = PSI_W'(p);
                e.last = (r + 1 == len);
                pending = {pending, e};
            end
            held = 0;
            max_vtx = 0;
            max_tim = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endtask

        task check_entry(logic [OUT_DATA_W-1:0] d, logic lst);
            table_entry_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", d, 0);
                return;
            end
            w = pending.pop_front();
            if (d[5:0] !== w.rank) report_mismatch("rank_index", d[5:0], w.rank);
            if (d[12:6] !== w.start) report_mismatch("suffix_start", d[12:6], w.start);
            if (d[19:13] !== w.psi) report_mismatch("psi_value", d[19:13], w.psi);
            if (d[23:20] !== 4'd0) report_mismatch("pad", d[23:20], 0);
            if (lst !== w.last) report_mismatch("last_result", lst, w.last);
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;

    psi_table_board board;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles = 0;

    temporal_graph_suffix_array_psi_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, check on each transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_entry(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task send_contact(logic [63:0] d, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_contact(d, lst);
    endtask

    function logic [15:0] pick_value(int mode);
        case (mode)
            0: return 16'($urandom_range(3));
            1: return 16'(16'hFFFF - $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // one contact set of a given size; small value ranges force long shared prefixes
    task send_set(int count, int mode);
        logic [63:0] d;
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < 4; k++) d[16*k +: 16] = pick_value(mode);
            send_contact(d, i == count - 1);
        end
    endtask

    initial begin
        int sent;
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: single contacts, extremes, full and overfull sets
        send_contact(64'h0, 1'b1);
        send_contact(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_contact(64'h0001_0000_FFFF_0000, 1'b0);
        send_contact(64'hFFFF_0000_0001_FFFF, 1'b1);
        send_set(NCT, 0);
        // overfull: extra contacts are dropped, last one still closes the set
        for (int i = 0; i < NCT + 3; i++)
            send_contact({4{16'(i == NCT + 1 ? 16'hFFFF : i % 3)}}, i == NCT + 2);
        sent = 2 * NCT + 7;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < 7; n++) begin
                int sz;
                sz = (n == 3) ? NCT : $urandom_range(1, 3);
                send_set(sz, $urandom_range(3));
                sent += sz;
            end
        end
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
